>>> rtl/core/smao_pkg.sv
// Shared types and constants for the swerve module angle optimizer.
// Holds the configuration register codes, the range window struct and the
// CORDIC arctangent table. Depends on nothing.
package smao_pkg;

  localparam int SPEED_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CMP_W       = 25;
  localparam int XY_W        = 34;
  localparam int Z_W         = 32;
  localparam int CORDIC_GAIN = 652032874;

  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MIN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MAX    = 2'd2;

  typedef struct packed {
    logic                         range_enable;
    logic signed [CFG_DATA_W-1:0] range_min;
    logic signed [CFG_DATA_W-1:0] range_max;
  } range_cfg_t;

  // Arctangent of 2^-idx as a 32-bit binary angle.
  function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
    logic signed [Z_W-1:0] val;
    begin
      case (idx)
        0:       val = 32'sh20000000;
        1:       val = 32'sh12E4051E;
        2:       val = 32'sh09FB385B;
        3:       val = 32'sh051111D4;
        4:       val = 32'sh028B0D43;
        5:       val = 32'sh0145D7E1;
        6:       val = 32'sh00A2F61E;
        7:       val = 32'sh00517C55;
        8:       val = 32'sh0028BE53;
        9:       val = 32'sh00145F2F;
        10:      val = 32'sh000A2F98;
        11:      val = 32'sh000517CC;
        12:      val = 32'sh00028BE6;
        13:      val = 32'sh000145F3;
        14:      val = 32'sh0000A2FA;
        15:      val = 32'sh0000517D;
        16:      val = 32'sh000028BE;
        17:      val = 32'sh0000145F;
        18:      val = 32'sh00000A30;
        19:      val = 32'sh00000518;
        20:      val = 32'sh0000028C;
        21:      val = 32'sh00000146;
        22:      val = 32'sh000000A3;
        23:      val = 32'sh00000051;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

>>> rtl/core/smao_fifo.sv
// Small first-in first-out queue built from a register array.
// Used between the front and back parts and at the result side.
// Depends on nothing.
module smao_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == {1'b1, {AW{1'b0}}});
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/smao_front.sv
// Front part: classifies one request into target, flip and folded distance.
// Uses smao_pkg for the range window struct and widths.
// Purely combinational; the queue behind it holds the result.
module smao_front #(
  parameter int ANGLE_BITS = 16
) (
  input  smao_pkg::range_cfg_t                cfg,
  input  logic signed [ANGLE_BITS-1:0]        req_angle,
  input  logic signed [ANGLE_BITS-1:0]        pres_angle,
  output logic        [ANGLE_BITS-1:0]        target,
  output logic                                flipped,
  output logic                                fold,
  output logic        [ANGLE_BITS-1:0]        fold_angle
);

  localparam logic [ANGLE_BITS-1:0] PI   = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] PI_2 = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  logic [ANGLE_BITS-1:0] diff;
  logic [ANGLE_BITS-1:0] span;
  logic [ANGLE_BITS-1:0] flip_tgt;
  logic                  far;
  logic                  req_out;
  logic                  flip_out;
  logic                  want_flip;
  logic                  revert;

  function automatic logic out_window(input logic signed [ANGLE_BITS-1:0] a,
                                      input smao_pkg::range_cfg_t c);
    logic signed [smao_pkg::CMP_W-1:0] ae;
    logic signed [smao_pkg::CMP_W-1:0] lo;
    logic signed [smao_pkg::CMP_W-1:0] hi;
    begin
      ae = smao_pkg::CMP_W'(a);
      lo = smao_pkg::CMP_W'(c.range_min);
      hi = smao_pkg::CMP_W'(c.range_max);
      return (ae > hi) || (ae < lo);
    end
  endfunction

  always_comb begin
    // The wrapped difference is a plain truncation of the subtraction.
    diff       = pres_angle - req_angle;
    span       = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
    far        = (span > PI_2);
    fold       = far;
    fold_angle = far ? (PI - span) : span;
    flip_tgt   = {~req_angle[ANGLE_BITS-1], req_angle[ANGLE_BITS-2:0]};
    req_out    = out_window(req_angle, cfg);
    flip_out   = out_window(flip_tgt, cfg);
    want_flip  = far || (cfg.range_enable && req_out);
    revert     = cfg.range_enable && flip_out;
    flipped    = want_flip && !revert;
    target     = flipped ? flip_tgt : req_angle;
  end

endmodule

>>> rtl/core/smao_back.sv
// Back part: pipelined CORDIC cosine, speed scaling and the result queue.
// Uses smao_pkg for the arctangent table and widths, and smao_fifo.
// Issue is credit based, so the pipeline itself never stalls.
module smao_back #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 src_valid,
  output logic                                 src_ready,
  input  logic        [ANGLE_BITS-1:0]         src_target,
  input  logic                                 src_flipped,
  input  logic                                 src_fold,
  input  logic        [ANGLE_BITS-1:0]         src_fold_angle,
  input  logic signed [smao_pkg::SPEED_W-1:0]  src_speed,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic        [ANGLE_BITS-1:0]         out_target,
  output logic signed [smao_pkg::SPEED_W-1:0]  out_drive,
  output logic                                 out_flipped
);

  localparam int XY_W      = smao_pkg::XY_W;
  localparam int Z_W       = smao_pkg::Z_W;
  localparam int SW        = smao_pkg::SPEED_W;
  localparam int OUT_AW    = $clog2(CORDIC_STAGES + 4);
  localparam int OUT_DEPTH = 1 << OUT_AW;
  localparam int PW        = OUT_AW + 1;
  localparam int OUT_W     = ANGLE_BITS + SW + 1;

  logic          take;
  logic          pop_ok;
  logic [PW-1:0] pend_r, pend_nxt;

  // CORDIC stage inputs, next values and registers.
  logic signed [XY_W-1:0]       x_in  [CORDIC_STAGES];
  logic signed [XY_W-1:0]       y_in  [CORDIC_STAGES];
  logic signed [Z_W-1:0]        z_in  [CORDIC_STAGES];
  logic                         v_in  [CORDIC_STAGES];
  logic        [ANGLE_BITS-1:0] t_in  [CORDIC_STAGES];
  logic                         f_in  [CORDIC_STAGES];
  logic                         fo_in [CORDIC_STAGES];
  logic signed [SW-1:0]         s_in  [CORDIC_STAGES];
  logic signed [XY_W-1:0]       x_nxt [CORDIC_STAGES];
  logic signed [XY_W-1:0]       y_nxt [CORDIC_STAGES];
  logic signed [Z_W-1:0]        z_nxt [CORDIC_STAGES];
  logic signed [XY_W-1:0]       x_r   [CORDIC_STAGES];
  logic signed [XY_W-1:0]       y_r   [CORDIC_STAGES];
  logic signed [Z_W-1:0]        z_r   [CORDIC_STAGES];
  logic                         v_r   [CORDIC_STAGES];
  logic        [ANGLE_BITS-1:0] t_r   [CORDIC_STAGES];
  logic                         f_r   [CORDIC_STAGES];
  logic                         fo_r  [CORDIC_STAGES];
  logic signed [SW-1:0]         s_r   [CORDIC_STAGES];

  // Cosine stage.
  logic signed [XY_W-1:0]       xr;
  logic signed [XY_W-1:0]       cneg;
  logic signed [SW-1:0]         cos_nxt, cos_r;
  logic                         cv_r;
  logic        [ANGLE_BITS-1:0] ct_r;
  logic                         cf_r;
  logic signed [SW-1:0]         cs_r;

  // Product stage.
  logic signed [2*SW-1:0]       prod_nxt, prod_r;
  logic                         pv_r;
  logic        [ANGLE_BITS-1:0] pt_r;
  logic                         pf_r;

  logic signed [XY_W-1:0]       rnd;
  logic signed [SW-1:0]         drive;
  logic        [OUT_W-1:0]      out_word;

  function automatic logic signed [SW-1:0] sat16(input logic signed [XY_W-1:0] v);
    logic signed [SW-1:0] r;
    begin
      if (v > XY_W'(32767)) begin
        r = 16'sh7FFF;
      end else if (v < -XY_W'(32768)) begin
        r = 16'sh8000;
      end else begin
        r = v[SW-1:0];
      end
      return r;
    end
  endfunction

  // Credit counter: items in the pipeline plus items in the result queue.
  assign src_ready = (pend_r != PW'(OUT_DEPTH));
  assign take      = src_valid && src_ready;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    pend_nxt = pend_r;
    if (take && !pop_ok) begin
      pend_nxt = pend_r + 1'b1;
    end else if (pop_ok && !take) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign x_in[i]  = XY_W'(smao_pkg::CORDIC_GAIN);
      assign y_in[i]  = '0;
      assign z_in[i]  = {src_fold_angle, {(Z_W-ANGLE_BITS){1'b0}}};
      assign v_in[i]  = take;
      assign t_in[i]  = src_target;
      assign f_in[i]  = src_flipped;
      assign fo_in[i] = src_fold;
      assign s_in[i]  = src_speed;
    end else begin : g_rest
      assign x_in[i]  = x_r[i-1];
      assign y_in[i]  = y_r[i-1];
      assign z_in[i]  = z_r[i-1];
      assign v_in[i]  = v_r[i-1];
      assign t_in[i]  = t_r[i-1];
      assign f_in[i]  = f_r[i-1];
      assign fo_in[i] = fo_r[i-1];
      assign s_in[i]  = s_r[i-1];
    end

    always_comb begin
      if (!z_in[i][Z_W-1]) begin
        x_nxt[i] = x_in[i] - (y_in[i] >>> i);
        y_nxt[i] = y_in[i] + (x_in[i] >>> i);
        z_nxt[i] = z_in[i] - smao_pkg::atan_entry(i);
      end else begin
        x_nxt[i] = x_in[i] + (y_in[i] >>> i);
        y_nxt[i] = y_in[i] - (x_in[i] >>> i);
        z_nxt[i] = z_in[i] + smao_pkg::atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]  <= x_nxt[i];
      y_r[i]  <= y_nxt[i];
      z_r[i]  <= z_nxt[i];
      t_r[i]  <= t_in[i];
      f_r[i]  <= f_in[i];
      fo_r[i] <= fo_in[i];
      s_r[i]  <= s_in[i];
    end
  end

  // Round x to Q1.15, negate when the distance was folded, saturate.
  always_comb begin
    xr      = (x_r[CORDIC_STAGES-1] + XY_W'(16384)) >>> 15;
    cneg    = fo_r[CORDIC_STAGES-1] ? -xr : xr;
    cos_nxt = sat16(cneg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      cv_r <= v_r[CORDIC_STAGES-1];
      pv_r <= cv_r;
    end
  end

  assign prod_nxt = cs_r * cos_r;

  always_ff @(posedge clk) begin
    cos_r  <= cos_nxt;
    ct_r   <= t_r[CORDIC_STAGES-1];
    cf_r   <= f_r[CORDIC_STAGES-1];
    cs_r   <= s_r[CORDIC_STAGES-1];
    prod_r <= prod_nxt;
    pt_r   <= ct_r;
    pf_r   <= cf_r;
  end

  // Round the Q5.27 product to Q4.12 and saturate.
  always_comb begin
    rnd      = (XY_W'(prod_r) + XY_W'(16384)) >>> 15;
    drive    = sat16(rnd);
    out_word = {pt_r, drive, pf_r};
  end

  smao_fifo #(
    .WIDTH (OUT_W),
    .AW    (OUT_AW)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pv_r),
    .wr_data (out_word),
    .rd_en   (pop_ok),
    .rd_data ({out_target, out_drive, out_flipped}),
    .empty   (out_empty),
    .full    ()
  );

endmodule

>>> rtl/core/swerve_module_angle_optimizer.sv
// An accepted push passes the request queue, the CORDIC stages, the cosine and
// product stages and the result queue. Throughput: one request per cycle while
// no full queue holds the flow, set by the fully pipelined CORDIC and the one
// multiplier stage; the result queue holds up to 2^ceil(log2(S+4)).
// Reset (synchronous, rst_n low) empties both queues and the pipeline and
// returns the range registers to enable 0, min -23666, max 23666.
module swerve_module_angle_optimizer #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Request channel.
  input  logic                                     in_push,
  output logic                                     in_full,
  input  logic signed [ANGLE_BITS-1:0]             in_requested_angle,
  input  logic signed [smao_pkg::SPEED_W-1:0]      in_requested_speed,
  input  logic signed [ANGLE_BITS-1:0]             in_present_angle,
  // Result channel.
  output logic                                     out_empty,
  input  logic                                     out_pop,
  output logic signed [ANGLE_BITS-1:0]             out_target_angle,
  output logic signed [smao_pkg::SPEED_W-1:0]      out_drive_speed,
  output logic                                     out_flipped,
  // Configuration write channel.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic        [smao_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic        [smao_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The request queue word carries the classified request from the front
  // part to the back part: target, flip, fold, folded distance and speed.
  localparam int SW    = smao_pkg::SPEED_W;
  localparam int MID_W = 2 * ANGLE_BITS + 2 + SW;
  localparam int MID_AW = 2;

  smao_pkg::range_cfg_t cfg_r, cfg_nxt;

  logic                  in_take;
  logic                  mid_full;
  logic                  mid_empty;
  logic                  mid_pop;
  logic [MID_W-1:0]      mid_wr_data;
  logic [MID_W-1:0]      mid_rd_data;

  logic [ANGLE_BITS-1:0] fr_target;
  logic                  fr_flipped;
  logic                  fr_fold;
  logic [ANGLE_BITS-1:0] fr_fold_angle;

  logic                  bk_ready;
  logic [ANGLE_BITS-1:0] bk_target;
  logic                  bk_flipped;
  logic                  bk_fold;
  logic [ANGLE_BITS-1:0] bk_fold_angle;
  logic signed [SW-1:0]  bk_speed;
  logic [ANGLE_BITS-1:0] res_target;

  // Configuration is accepted in every cycle. Writes to the unused index
  // are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        smao_pkg::CFG_RANGE_ENABLE: cfg_nxt.range_enable = cfg_data[0];
        smao_pkg::CFG_RANGE_MIN:    cfg_nxt.range_min    = cfg_data;
        smao_pkg::CFG_RANGE_MAX:    cfg_nxt.range_max    = cfg_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_enable <= 1'b0;
      cfg_r.range_min    <= -16'sd23666;
      cfg_r.range_max    <= 16'sd23666;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front part: the request is classified in the cycle it is pushed, and
  // the outcome lands in a four-entry queue. The front only stalls when
  // that queue is full.
  smao_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .cfg        (cfg_r),
    .req_angle  (in_requested_angle),
    .pres_angle (in_present_angle),
    .target     (fr_target),
    .flipped    (fr_flipped),
    .fold       (fr_fold),
    .fold_angle (fr_fold_angle)
  );

  assign in_full     = mid_full;
  assign in_take     = in_push && !mid_full;
  assign mid_wr_data = {fr_target, fr_flipped, fr_fold, fr_fold_angle, in_requested_speed};

  smao_fifo #(
    .WIDTH (MID_W),
    .AW    (MID_AW)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_take),
    .wr_data (mid_wr_data),
    .rd_en   (mid_pop),
    .rd_data (mid_rd_data),
    .empty   (mid_empty),
    .full    (mid_full)
  );

  assign {bk_target, bk_flipped, bk_fold, bk_fold_angle, bk_speed} = mid_rd_data;
  assign mid_pop = !mid_empty && bk_ready;

  // Back part: it takes the next classified request whenever the result
  // queue has a free slot reserved for it, so a slow consumer only backs
  // up the request queue and never stalls the CORDIC pipeline.
  smao_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .src_valid      (!mid_empty),
    .src_ready      (bk_ready),
    .src_target     (bk_target),
    .src_flipped    (bk_flipped),
    .src_fold       (bk_fold),
    .src_fold_angle (bk_fold_angle),
    .src_speed      (bk_speed),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_target     (res_target),
    .out_drive      (out_drive_speed),
    .out_flipped    (out_flipped)
  );

  assign out_target_angle = res_target;

endmodule
